FILE: rtl/nsc_pkg.sv
// Shared types, character codes and type lookup for the NMEA sentence checker.
package nsc_pkg;

  // ASCII codes that steer the parser.
  localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_CR      = 8'h0D;

  // Known sentence types, first character in the top byte.
  localparam logic [39:0] TYPE_GPGSA = 40'h47_50_47_53_41;
  localparam logic [39:0] TYPE_GPGGA = 40'h47_50_47_47_41;
  localparam logic [39:0] TYPE_GPRMC = 40'h47_50_52_4D_43;
  localparam logic [39:0] TYPE_GPGSV = 40'h47_50_47_53_56;

  // Type codes reported in the result.
  localparam logic [1:0] CODE_GPGSA = 2'd0;
  localparam logic [1:0] CODE_GPGGA = 2'd1;
  localparam logic [1:0] CODE_GPRMC = 2'd2;
  localparam logic [1:0] CODE_GPGSV = 2'd3;

  // Number of characters that make up the sentence type.
  localparam logic [2:0] TYPE_LEN = 3'd5;

  // Default depth of the token queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Character classes produced by the front end.
  typedef enum logic [2:0] {
    TOK_OTHER,
    TOK_DOLLAR,
    TOK_NEWLINE,
    TOK_STAR,
    TOK_CR,
    TOK_HEX
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [3:0]  hex;
    logic [7:0]  ch;
  } token_t;

  typedef enum logic [1:0] {
    MODE_HUNT = 2'd0,
    MODE_BODY = 2'd1,
    MODE_SUM  = 2'd2
  } parse_mode_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic        sum_well_formed;
    logic        sum_match;
    logic [7:0]  received_sum;
    logic [7:0]  computed_sum;
    logic [1:0]  sentence_type;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic       found;
    logic [1:0] code;
  } type_match_t;

  // Looks up a captured five-character type.
  function automatic type_match_t match_type(input logic [39:0] chars);
    type_match_t m;
    m.found = 1'b1;
    m.code  = CODE_GPGSA;
    priority if (chars == TYPE_GPGSA) begin
      m.code = CODE_GPGSA;
    end else if (chars == TYPE_GPGGA) begin
      m.code = CODE_GPGGA;
    end else if (chars == TYPE_GPRMC) begin
      m.code = CODE_GPRMC;
    end else if (chars == TYPE_GPGSV) begin
      m.code = CODE_GPGSV;
    end else begin
      m.found = 1'b0;
    end
    return m;
  endfunction

endpackage

FILE: rtl/nsc_front.sv
// Front end: accepts characters and classifies them into tokens.
module nsc_front
  import nsc_pkg::*;
(
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] in_char
  output logic        push,
  output token_t      push_tok,
  input  q_status_t   q_stat
);

  logic [7:0] c;

  assign c        = s_tdata;
  assign s_tready = !rst && !q_stat.full;
  assign push     = s_tvalid && s_tready;

  // Classify the character and work out its hex value where it has one.
  always_comb begin
    push_tok.ch   = c;
    push_tok.hex  = 4'd0;
    push_tok.kind = TOK_OTHER;
    if (c == CHAR_DOLLAR) begin
      push_tok.kind = TOK_DOLLAR;
    end else if (c == CHAR_NEWLINE) begin
      push_tok.kind = TOK_NEWLINE;
    end else if (c == CHAR_STAR) begin
      push_tok.kind = TOK_STAR;
    end else if (c == CHAR_CR) begin
      push_tok.kind = TOK_CR;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      push_tok.kind = TOK_HEX;
      push_tok.hex  = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      push_tok.kind = TOK_HEX;
      push_tok.hex  = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      push_tok.kind = TOK_HEX;
      push_tok.hex  = 4'(c - 8'h57);
    end
  end

endmodule

FILE: rtl/nsc_queue.sv
// Short token queue that decouples the front end from the parser.
module nsc_queue
  import nsc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  token_t     push_tok,
  input  logic       pop,
  output logic       tok_valid,
  output token_t     tok,
  output q_status_t  q_stat
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  token_t            mem [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push;
  logic              do_pop;

  assign q_stat.full  = (count == CntW'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign tok_valid    = !q_stat.empty;
  assign tok          = mem[rd_ptr];
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/nsc_back.sv
// Back end: sentence parser, checksum logic and the output register.
module nsc_back
  import nsc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         tok_valid,
  input  token_t       tok,
  output logic         pop,
  output logic         m_tvalid,
  input  logic         m_tready,
  output result_t      res
);

  parse_mode_t  mode, mode_next;
  logic [39:0]  type_chars, type_chars_next;
  logic [2:0]   type_count, type_count_next;
  logic [7:0]   running_xor, running_xor_next;
  logic [7:0]   sum_digits, sum_digits_next;
  logic [1:0]   digit_count, digit_count_next;
  logic         bad_digit, bad_digit_next;
  logic [1:0]   type_index, type_index_next;
  logic         emit;
  logic         well_formed;
  type_match_t  tm;

  // A token is taken whenever the output register can hold a new result.
  assign pop         = tok_valid && (!m_tvalid || m_tready);
  assign tm          = match_type(type_chars);
  assign well_formed = (digit_count == 2'd2) && !bad_digit;
  assign emit        = pop && (tok.kind == TOK_NEWLINE) && (mode == MODE_SUM);

  // Next parse mode.
  always_comb begin
    mode_next = mode;
    if (pop) begin
      if (tok.kind == TOK_DOLLAR) begin
        mode_next = MODE_BODY;
      end else begin
        unique case (mode)
          MODE_BODY: begin
            if (tok.kind == TOK_NEWLINE) begin
              mode_next = MODE_HUNT;
            end else if (tok.kind == TOK_STAR) begin
              mode_next = (tm.found && type_count == TYPE_LEN) ? MODE_SUM : MODE_HUNT;
            end
          end
          MODE_SUM: begin
            if (tok.kind == TOK_NEWLINE) begin
              mode_next = MODE_HUNT;
            end
          end
          default: mode_next = MODE_HUNT;
        endcase
      end
    end
  end

  // Sentence state updates driven by the current mode.
  always_comb begin
    type_chars_next  = type_chars;
    type_count_next  = type_count;
    running_xor_next = running_xor;
    sum_digits_next  = sum_digits;
    digit_count_next = digit_count;
    bad_digit_next   = bad_digit;
    type_index_next  = type_index;
    if (pop) begin
      if (tok.kind == TOK_DOLLAR) begin
        type_chars_next  = '0;
        type_count_next  = '0;
        running_xor_next = '0;
        sum_digits_next  = '0;
        digit_count_next = '0;
        bad_digit_next   = 1'b0;
      end else begin
        unique case (mode)
          MODE_BODY: begin
            if (tok.kind == TOK_NEWLINE) begin
              type_chars_next  = '0;
              type_count_next  = '0;
              running_xor_next = '0;
            end else if (tok.kind == TOK_STAR) begin
              if (tm.found && type_count == TYPE_LEN) begin
                type_index_next  = tm.code;
                sum_digits_next  = '0;
                digit_count_next = '0;
                bad_digit_next   = 1'b0;
              end else begin
                type_chars_next  = '0;
                type_count_next  = '0;
                running_xor_next = '0;
              end
            end else begin
              running_xor_next = running_xor ^ tok.ch;
              if (type_count < TYPE_LEN) begin
                type_chars_next = {type_chars[31:0], tok.ch};
                type_count_next = type_count + 3'd1;
              end
            end
          end
          MODE_SUM: begin
            if (tok.kind == TOK_NEWLINE) begin
              type_chars_next  = '0;
              type_count_next  = '0;
              running_xor_next = '0;
            end else if (tok.kind == TOK_HEX) begin
              sum_digits_next = {sum_digits[3:0], tok.hex};
              if (digit_count != 2'd3) begin
                digit_count_next = digit_count + 2'd1;
              end
            end else if (tok.kind != TOK_CR) begin
              bad_digit_next = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_HUNT;
      type_chars  <= '0;
      type_count  <= '0;
      running_xor <= '0;
      sum_digits  <= '0;
      digit_count <= '0;
      bad_digit   <= 1'b0;
      type_index  <= '0;
    end else begin
      mode        <= mode_next;
      type_chars  <= type_chars_next;
      type_count  <= type_count_next;
      running_xor <= running_xor_next;
      sum_digits  <= sum_digits_next;
      digit_count <= digit_count_next;
      bad_digit   <= bad_digit_next;
      type_index  <= type_index_next;
    end
  end

  // Output register: loads a result at the closing newline, clears once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.sentence_type   <= type_index;
      res.computed_sum    <= running_xor;
      res.received_sum    <= sum_digits;
      res.sum_well_formed <= well_formed;
      res.sum_match       <= well_formed && (sum_digits == running_xor);
    end
  end

endmodule

FILE: rtl/nmea_sentence_checker.sv
// Top level of the NMEA 0183 sentence checksum checker.
//
// Characters enter one per beat on the slave stream (s_tdata holds the
// character). A sentence starts at a dollar sign; the characters up to the
// asterisk are XORed into the computed checksum and the first five name the
// type. Only GPGSA, GPGGA, GPRMC and GPGSV sentences are kept. The closing
// newline after the checksum digits yields one result beat on the master
// stream with type code, both checksums, a match flag and a format flag.
// All other characters yield nothing.
// Throughput: one character per cycle while the receiver does not stall. The
// front end classifies a character into the token queue in the cycle it is
// accepted; the parser takes one token per cycle from the queue, and a result
// beat is loaded into the output register when the parser takes its newline.
// When the receiver stalls, the result waits in the output register and the
// parser halts; the queue then fills and s_tready drops once it is full.
// Reset returns the parser to hunting for a dollar sign and empties the queue.
module nmea_sentence_checker
  import nsc_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
)
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] in_char
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [23:0]  m_tdata    // [1:0] sentence_type, [9:2] computed_sum,
                                  // [17:10] received_sum, [18] sum_match,
                                  // [19] sum_well_formed, [23:20] zero
);

  logic       push;
  token_t     push_tok;
  q_status_t  q_stat;
  logic       tok_valid;
  token_t     tok;
  logic       pop;
  result_t    res;

  nsc_front u_front (
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .push     (push),
    .push_tok (push_tok),
    .q_stat   (q_stat)
  );

  nsc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_tok  (push_tok),
    .pop       (pop),
    .tok_valid (tok_valid),
    .tok       (tok),
    .q_stat    (q_stat)
  );

  nsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok       (tok),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .res       (res)
  );

  assign m_tdata = {4'b0000, res};

  // A queue cannot be full and empty at once.
  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("token queue reports full and empty together");

  // A match is only reported for a well-formed checksum field.
  a_match_formed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.sum_match |-> res.sum_well_formed)
    else $error("checksum match without a well-formed field");

  // A new result needs a token taken from the queue in the cycle before.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(tok_valid && pop))
    else $error("result appeared without a token");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid straight after reset");

endmodule
